### design/weight_change_event_detector_defines.svh
// Assertion macros for the weight change event detector checker.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef WEIGHT_CHANGE_EVENT_DETECTOR_DEFINES_SVH
`define WEIGHT_CHANGE_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, off during reset
`define WCED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define WCED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define WCED_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wced_pkg.sv
// Shared types and constants for the weight change event detector.
// Used by the register block, the tick core, the top level and the checker.
`timescale 1ns / 1ps

package wced_pkg;

  // Field widths
  localparam int WEIGHT_BITS       = 24;
  localparam int COUNTER_BITS_DEF  = 16;
  localparam int TICK_CFG_BITS     = 16;
  localparam int NOISE_BITS        = 23;
  localparam int NET_BITS          = 32;
  localparam int GRAM_SHIFT        = 4;
  localparam int GRAMS_BITS        = NET_BITS - 1 - GRAM_SHIFT;
  localparam int ADDR_BITS         = 4;
  localparam int DATA_BITS         = 32;

  // Reset values of the registers
  localparam logic [TICK_CFG_BITS-1:0] MEASURE_RESET = TICK_CFG_BITS'(40);
  localparam logic [TICK_CFG_BITS-1:0] STABLE_RESET  = TICK_CFG_BITS'(100);
  localparam logic [NOISE_BITS-1:0]    NOISE_RESET   = NOISE_BITS'(160);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_MEASURE = 2'd0,
    REG_STABLE  = 2'd1,
    REG_NOISE   = 2'd2
  } reg_index_t;

  // Event kinds
  typedef enum logic [1:0] {
    KIND_DRINK   = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_DISCARD = 2'd2
  } volume_kind_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_sample;
    logic                          lid_is_closed;
  } tick_t;

  typedef struct packed {
    logic                  lid_changed;
    logic                  lid_now_closed;
    logic                  volume_event;
    logic [1:0]            volume_kind;
    logic [GRAMS_BITS-1:0] volume_grams;
  } report_t;

  typedef struct packed {
    logic [TICK_CFG_BITS-1:0] measure_ticks;
    logic [TICK_CFG_BITS-1:0] stable_ticks;
    logic [NOISE_BITS-1:0]    noise_threshold;
  } cfg_t;

endpackage

### design/wced_cfg.sv
// APB-style register block holding the three detector settings.
// Depends on wced_pkg for the register indexes and the settings struct.
`timescale 1ns / 1ps

module wced_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wced_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wced_pkg::DATA_BITS-1:0] pwdata,
  output logic [wced_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output wced_pkg::cfg_t                 cfg
);

  wced_pkg::reg_index_t index;
  logic                 wr;

  assign index  = wced_pkg::reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Write the addressed register; drop writes to unused addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.measure_ticks   <= wced_pkg::MEASURE_RESET;
      cfg.stable_ticks    <= wced_pkg::STABLE_RESET;
      cfg.noise_threshold <= wced_pkg::NOISE_RESET;
    end else if (wr) begin
      unique case (index)
        wced_pkg::REG_MEASURE: begin
          cfg.measure_ticks <= pwdata[wced_pkg::TICK_CFG_BITS-1:0];
        end
        wced_pkg::REG_STABLE: begin
          cfg.stable_ticks <= pwdata[wced_pkg::TICK_CFG_BITS-1:0];
        end
        wced_pkg::REG_NOISE: begin
          cfg.noise_threshold <= pwdata[wced_pkg::NOISE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (index)
      wced_pkg::REG_MEASURE: prdata = wced_pkg::DATA_BITS'(cfg.measure_ticks);
      wced_pkg::REG_STABLE:  prdata = wced_pkg::DATA_BITS'(cfg.stable_ticks);
      wced_pkg::REG_NOISE:   prdata = wced_pkg::DATA_BITS'(cfg.noise_threshold);
      default:               prdata = '0;
    endcase
  end

endmodule

### design/wced_core.sv
// Per-tick state and update logic: lid edges, weight sampling, net change
// accumulation and settle detection. Depends on wced_pkg.
`timescale 1ns / 1ps

module wced_core #(
  parameter int COUNTER_BITS = wced_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wced_pkg::tick_t   tick,
  input  wced_pkg::cfg_t    cfg,
  output logic              has_result,
  output wced_pkg::report_t result
);

  localparam int W    = wced_pkg::WEIGHT_BITS;
  localparam int DW   = W + 1;
  localparam int NB   = wced_pkg::NET_BITS;
  localparam int TB   = wced_pkg::TICK_CFG_BITS;
  localparam int CMPW = (COUNTER_BITS > TB) ? COUNTER_BITS : TB;
  localparam int MW   = (DW > wced_pkg::NOISE_BITS) ? DW : wced_pkg::NOISE_BITS;
  localparam int SUMW = ((NB > DW) ? NB : DW) + 1;
  localparam logic signed [SUMW-1:0] NET_POS =
    {{(SUMW-NB+1){1'b0}}, {(NB-1){1'b1}}};
  localparam logic signed [SUMW-1:0] NET_NEG = -NET_POS;

  // State
  logic                    primed;
  logic                    prev_lid;
  logic signed [W-1:0]     prev_weight;
  logic signed [NB-1:0]    net_change;
  logic [COUNTER_BITS-1:0] since_sample;
  logic [COUNTER_BITS-1:0] since_change;

  logic                    primed_next;
  logic                    prev_lid_next;
  logic signed [W-1:0]     prev_weight_next;
  logic signed [NB-1:0]    net_change_next;
  logic [COUNTER_BITS-1:0] since_sample_next;
  logic [COUNTER_BITS-1:0] since_change_next;

  // Datapath
  logic [COUNTER_BITS-1:0] sample_adv;
  logic [COUNTER_BITS-1:0] change_adv;
  logic                    sample;
  logic signed [DW-1:0]    diff;
  logic [DW-1:0]           mag;
  logic                    big;
  logic signed [SUMW-1:0]  sum;
  logic signed [SUMW-1:0]  sum_sat;
  logic signed [NB-1:0]    net_mid;
  logic [COUNTER_BITS-1:0] change_mid;
  logic                    fire;
  logic [NB-1:0]           amag;

  // Advance both tick counters, holding at full scale
  assign sample_adv = (&since_sample) ? since_sample : since_sample + 1'b1;
  assign change_adv = (&since_change) ? since_change : since_change + 1'b1;
  assign sample     = CMPW'(sample_adv) >= CMPW'(cfg.measure_ticks);

  // Weight delta and its magnitude against the noise floor
  assign diff = $signed({tick.weight_sample[W-1], tick.weight_sample})
              - $signed({prev_weight[W-1], prev_weight});
  assign mag  = diff[DW-1] ? (~diff + 1'b1) : diff;
  assign big  = MW'(mag) > MW'(cfg.noise_threshold);

  // Saturating accumulate
  assign sum = SUMW'(net_change) + SUMW'(diff);
  always_comb begin
    if (sum > NET_POS) begin
      sum_sat = NET_POS;
    end else if (sum < NET_NEG) begin
      sum_sat = NET_NEG;
    end else begin
      sum_sat = sum;
    end
  end

  assign net_mid    = (sample && big) ? sum_sat[NB-1:0] : net_change;
  assign change_mid = (sample && big) ? '0 : change_adv;

  // Settle check on the updated accumulator
  assign fire = (net_mid != '0) && (CMPW'(change_mid) >= CMPW'(cfg.stable_ticks));
  assign amag = net_mid[NB-1] ? (~net_mid + 1'b1) : net_mid;

  // Result word
  always_comb begin
    result.lid_changed    = tick.lid_is_closed != prev_lid;
    result.lid_now_closed = tick.lid_is_closed;
    result.volume_event   = fire;
    result.volume_kind    = wced_pkg::KIND_DRINK;
    result.volume_grams   = '0;
    if (fire) begin
      if (!net_mid[NB-1]) begin
        result.volume_kind = wced_pkg::KIND_ADD;
      end else if (tick.lid_is_closed) begin
        result.volume_kind = wced_pkg::KIND_DISCARD;
      end
      result.volume_grams =
        amag[wced_pkg::GRAMS_BITS+wced_pkg::GRAM_SHIFT-1:wced_pkg::GRAM_SHIFT];
    end
  end

  assign has_result = primed;

  // Next state; the first tick only primes weight and lid
  always_comb begin
    primed_next      = 1'b1;
    prev_lid_next    = tick.lid_is_closed;
    if (!primed) begin
      prev_weight_next  = tick.weight_sample;
      net_change_next   = net_change;
      since_sample_next = '0;
      since_change_next = '0;
    end else begin
      prev_weight_next  = sample ? tick.weight_sample : prev_weight;
      since_sample_next = sample ? '0 : sample_adv;
      net_change_next   = fire ? '0 : net_mid;
      since_change_next = fire ? '0 : change_mid;
    end
  end

  // Hold state; advance on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      primed       <= 1'b0;
      prev_lid     <= 1'b0;
      prev_weight  <= '0;
      net_change   <= '0;
      since_sample <= '0;
      since_change <= '0;
    end else if (step) begin
      primed       <= primed_next;
      prev_lid     <= prev_lid_next;
      prev_weight  <= prev_weight_next;
      net_change   <= net_change_next;
      since_sample <= since_sample_next;
      since_change <= since_change_next;
    end
  end

endmodule

### design/weight_change_event_detector.sv
// Top level of the weight change event detector: input and report registers,
// handshake control, register block and tick core. Depends on wced_pkg.
//
//   channel  direction  handshake                 word
//   tick     in         tick_valid / tick_ready    wced_pkg::tick_t
//   report   out        report_valid / report_ready wced_pkg::report_t
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One tick word per cycle unless reports stall, as the tick core updates its state
// on each step; a taken tick sits in the input register, then loads the report register.
// The first tick after reset primes the stored weight and lid and gives no report.
// Synchronous reset (rst) clears valid bits and core state, restores register defaults.
// A stalled report holds the input register; a new tick is taken whenever
// the input register is empty or moves on in the same cycle.
`timescale 1ns / 1ps

module weight_change_event_detector #(
  parameter int COUNTER_BITS = wced_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_ready,
  input  wced_pkg::tick_t                tick,
  output logic                           report_valid,
  input  logic                           report_ready,
  output wced_pkg::report_t              report,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wced_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wced_pkg::DATA_BITS-1:0] pwdata,
  output logic [wced_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  wced_pkg::cfg_t    cfg;
  wced_pkg::tick_t   tick_q;
  logic              tick_q_valid;
  logic              step;
  logic              has_result;
  wced_pkg::report_t result;

  wced_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wced_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .tick       (tick_q),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  // Process the held tick when the report register is free or draining
  assign step       = tick_q_valid && (!report_valid || report_ready);
  assign tick_ready = !tick_q_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick_ready) begin
      tick_q_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      tick_q <= tick;
    end
  end

  // Report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (step && has_result) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      report <= result;
    end
  end

endmodule

### design/wced_checker.sv
// Port-level checks for the weight change event detector, bound to the top.
// Depends on wced_pkg and weight_change_event_detector_defines.svh.
`timescale 1ns / 1ps
`include "weight_change_event_detector_defines.svh"

module wced_checker (
  input logic              clk,
  input logic              rst,
  input logic              report_valid,
  input logic              report_ready,
  input wced_pkg::report_t report
);

  // Hold a stalled report word
  `WCED_ASSERT_NEXT(a_report_held, report_valid && !report_ready, report_valid, "report dropped while stalled")
  `WCED_ASSERT_NEXT(a_report_stable, report_valid && !report_ready, $stable(report), "report changed while stalled")

  // Kind and amount are zero without an event
  `WCED_ASSERT_IMPL(a_no_event_zero, report_valid && !report.volume_event, report.volume_kind == wced_pkg::KIND_DRINK && report.volume_grams == '0, "stray kind or amount")

  // An event always carries a nonzero change; a drink is reported only with the lid open
  `WCED_ASSERT_IMPL(a_event_kind, report_valid && report.volume_event && report.volume_kind == wced_pkg::KIND_DRINK, !report.lid_now_closed, "drink reported with lid closed")

  // Reset empties the report register
  `WCED_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !report_valid, "report valid after reset")

endmodule

bind weight_change_event_detector wced_checker u_wced_checker (
  .clk          (clk),
  .rst          (rst),
  .report_valid (report_valid),
  .report_ready (report_ready),
  .report       (report)
);

### tb/weight_change_event_detector_tb.sv
// Self-checking testbench for weight_change_event_detector: tick words in, report words out.
// The predictor, the report checker and the register programming live here.
// Depends on wced_pkg and the design files under design/.
`timescale 1ns / 1ps

module weight_change_event_detector_tb;

  localparam int     COUNTER_MAX     = (1 << wced_pkg::COUNTER_BITS_DEF) - 1;
  localparam longint NET_LIMIT       = (longint'(1) << (wced_pkg::NET_BITS - 1)) - 1;
  localparam int     WEIGHT_MAX      = (1 << (wced_pkg::WEIGHT_BITS - 1)) - 1;
  localparam int     WEIGHT_MIN      = -(1 << (wced_pkg::WEIGHT_BITS - 1));
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     MAX_PRINTED     = 50;
  localparam int     CLIMB_CYCLES    = 135;
  localparam int     IDLE_PCT        = 13;
  // first byte address past the last register
  localparam logic [wced_pkg::ADDR_BITS-1:0] UNUSED_ADDR = 4'hC;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           tick_valid = 1'b0;
  logic                           tick_ready;
  wced_pkg::tick_t                tick = '0;
  logic                           report_valid;
  logic                           report_ready = 1'b0;
  wced_pkg::report_t              report;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [wced_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [wced_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [wced_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  // Predictor state and its copy of the registers
  int     measure_period = 40;
  int     settle_period  = 100;
  int     jitter_limit   = 160;
  bit     seen_first_tick;
  bit     held_lid;
  longint held_weight;
  longint net_sixteenths;
  int     sample_age;
  int     quiet_age;

  wced_pkg::tick_t   ticks_to_send[$];
  wced_pkg::report_t reports_due[$];
  wced_pkg::report_t predicted_report;
  wced_pkg::report_t due_report;
  int                mismatch_count;
  int                quiet_cycles;
  int                send_idle_pct = IDLE_PCT;
  int                ready_idle_pct = IDLE_PCT;
  int                scale_level;
  bit                lid_closed_now;

  weight_change_event_detector DUT (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Advance the predictor by one tick word; returns 1 when a report is due
  function automatic bit predict_tick_report(input wced_pkg::tick_t t,
                                             output wced_pkg::report_t r);
    longint w;
    longint d;
    longint mag;
    longint sum;
    bit     lid;
    r   = '0;
    w   = longint'($signed(t.weight_sample));
    lid = t.lid_is_closed;

    // first word after reset only loads the stored weight and lid
    if (!seen_first_tick) begin
      seen_first_tick = 1'b1;
      held_weight     = w;
      held_lid        = lid;
      sample_age      = 0;
      quiet_age       = 0;
      return 1'b0;
    end

    r.lid_changed    = (lid != held_lid);
    r.lid_now_closed = lid;
    held_lid         = lid;

    sample_age = (sample_age >= COUNTER_MAX) ? COUNTER_MAX : sample_age + 1;
    quiet_age  = (quiet_age >= COUNTER_MAX) ? COUNTER_MAX : quiet_age + 1;

    // sample the weight; only changes above the jitter limit count
    if (sample_age >= measure_period) begin
      d          = w - held_weight;
      mag        = (d < 0) ? -d : d;
      sample_age = 0;
      if (mag > jitter_limit) begin
        sum = net_sixteenths + d;
        if (sum > NET_LIMIT) sum = NET_LIMIT;
        if (sum < -NET_LIMIT) sum = -NET_LIMIT;
        net_sixteenths = sum;
        quiet_age      = 0;
      end
      held_weight = w;
    end

    // report a settled total; the saturated total always fits the grams field
    if (net_sixteenths != 0 && quiet_age >= settle_period) begin
      r.volume_event = 1'b1;
      if (net_sixteenths > 0) begin
        r.volume_kind  = wced_pkg::KIND_ADD;
        r.volume_grams = wced_pkg::GRAMS_BITS'(net_sixteenths >>> wced_pkg::GRAM_SHIFT);
      end else begin
        r.volume_kind  = lid ? wced_pkg::KIND_DISCARD : wced_pkg::KIND_DRINK;
        r.volume_grams = wced_pkg::GRAMS_BITS'((-net_sixteenths) >>> wced_pkg::GRAM_SHIFT);
      end
      net_sixteenths = 0;
      quiet_age      = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic [wced_pkg::ADDR_BITS-1:0] reg_addr(input wced_pkg::reg_index_t idx);
    return wced_pkg::ADDR_BITS'(idx) << 2;
  endfunction

  function automatic logic signed [wced_pkg::WEIGHT_BITS-1:0] clamp_weight(input int w);
    if (w > WEIGHT_MAX) return wced_pkg::WEIGHT_BITS'(WEIGHT_MAX);
    if (w < WEIGHT_MIN) return wced_pkg::WEIGHT_BITS'(WEIGHT_MIN);
    return wced_pkg::WEIGHT_BITS'(w);
  endfunction

  // Tick word driver: take from the pending queue, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && tick_ready) begin
        if (predict_tick_report(tick, predicted_report)) begin
          reports_due.push_back(predicted_report);
        end
      end
      // offer the next word once the current one is gone
      if (!tick_valid || tick_ready) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick       <= ticks_to_send.pop_front();
          tick_valid <= 1'b1;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the report side at random
  always @(posedge clk) begin
    report_ready <= ($urandom_range(99) >= ready_idle_pct);
  end

  // Report monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && report_valid && report_ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("report word with none due", longint'(report), 0);
      end else begin
        due_report = reports_due.pop_front();
        if (report.lid_changed !== due_report.lid_changed)
          report_mismatch("lid_changed", longint'(report.lid_changed),
                          longint'(due_report.lid_changed));
        if (report.lid_now_closed !== due_report.lid_now_closed)
          report_mismatch("lid_now_closed", longint'(report.lid_now_closed),
                          longint'(due_report.lid_now_closed));
        if (report.volume_event !== due_report.volume_event)
          report_mismatch("volume_event", longint'(report.volume_event),
                          longint'(due_report.volume_event));
        if (report.volume_kind !== due_report.volume_kind)
          report_mismatch("volume_kind", longint'(report.volume_kind),
                          longint'(due_report.volume_kind));
        if (report.volume_grams !== due_report.volume_grams)
          report_mismatch("volume_grams", longint'(report.volume_grams),
                          longint'(due_report.volume_grams));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (report_valid && report_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("weight_change_event_detector_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [wced_pkg::ADDR_BITS-1:0] addr,
                           input logic [wced_pkg::DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // mirror the write into the predictor; unknown addresses are dropped
    case (addr[wced_pkg::ADDR_BITS-1:2])
      wced_pkg::REG_MEASURE: measure_period = int'(data[wced_pkg::TICK_CFG_BITS-1:0]);
      wced_pkg::REG_STABLE:  settle_period  = int'(data[wced_pkg::TICK_CFG_BITS-1:0]);
      wced_pkg::REG_NOISE:   jitter_limit   = int'(data[wced_pkg::NOISE_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [wced_pkg::ADDR_BITS-1:0] addr,
                          output logic [wced_pkg::DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_registers();
    logic [wced_pkg::DATA_BITS-1:0] got;
    apb_read(reg_addr(wced_pkg::REG_MEASURE), got);
    if (got !== wced_pkg::DATA_BITS'(measure_period))
      report_mismatch("measure_ticks read", longint'(got), measure_period);
    apb_read(reg_addr(wced_pkg::REG_STABLE), got);
    if (got !== wced_pkg::DATA_BITS'(settle_period))
      report_mismatch("stable_ticks read", longint'(got), settle_period);
    apb_read(reg_addr(wced_pkg::REG_NOISE), got);
    if (got !== wced_pkg::DATA_BITS'(jitter_limit))
      report_mismatch("noise_threshold read", longint'(got), jitter_limit);
  endtask

  task automatic configure(input logic [wced_pkg::DATA_BITS-1:0] measure,
                           input logic [wced_pkg::DATA_BITS-1:0] settle,
                           input logic [wced_pkg::DATA_BITS-1:0] noise);
    apb_write(reg_addr(wced_pkg::REG_MEASURE), measure);
    apb_write(reg_addr(wced_pkg::REG_STABLE), settle);
    apb_write(reg_addr(wced_pkg::REG_NOISE), noise);
    read_back_registers();
  endtask

  // Hold until every word is sent and every report is back, then let the pipe empty
  task automatic wait_for_quiet();
    while (ticks_to_send.size() != 0 || tick_valid || reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_tick(input int w, input bit lid);
    wced_pkg::tick_t t;
    t.weight_sample = clamp_weight(w);
    t.lid_is_closed = lid;
    ticks_to_send.push_back(t);
  endtask

  // Scale sitting at a level with jitter, with occasional pours, sips, lid moves and noise words
  task automatic queue_scale_activity(input int count, input int jitter, input int step_max);
    wced_pkg::tick_t t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 4) begin
        if ($urandom_range(1)) scale_level = scale_level + int'($urandom_range(step_max));
        else scale_level = scale_level - int'($urandom_range(step_max));
        scale_level = int'(clamp_weight(scale_level));
      end
      if ($urandom_range(99) < 3) lid_closed_now = !lid_closed_now;
      if ($urandom_range(99) < 10) begin
        // noise word: any reading, any lid
        t.weight_sample = wced_pkg::WEIGHT_BITS'($urandom);
        t.lid_is_closed = 1'($urandom_range(1));
        ticks_to_send.push_back(t);
      end else begin
        queue_tick(scale_level + int'($urandom_range(2 * jitter)) - jitter, lid_closed_now);
      end
    end
  endtask

  // Drive the total toward saturation: the two small steps sit exactly at the
  // jitter limit and are dropped, only the full-scale swing counts
  task automatic queue_accumulator_climb(input bit rising);
    int top;
    top = rising ? WEIGHT_MAX : -WEIGHT_MAX;
    for (int c = 0; c < CLIMB_CYCLES; c++) begin
      queue_tick(0, 1'($urandom_range(1)));
      queue_tick(-top, 1'($urandom_range(1)));
      queue_tick(top, 1'($urandom_range(1)));
    end
    // hold still so the saturated total settles and is reported
    repeat (8) queue_tick(top, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset values, first word primes the stored weight and lid
    read_back_registers();
    queue_scale_activity(160, 8, 4000);
    wait_for_quiet();

    // Sample and report on every tick; upper write bits and an unused address ignored
    apb_write(UNUSED_ADDR, 32'h0000_1234);
    configure(32'hBEEF_0000, 32'h0001_0000, 32'hFF80_0000);
    queue_tick(0, 1'b0);
    queue_tick(WEIGHT_MAX, 1'b1);
    queue_tick(WEIGHT_MIN, 1'b1);
    queue_tick(WEIGHT_MIN, 1'b0);
    queue_tick(WEIGHT_MAX, 1'b0);
    queue_tick(WEIGHT_MIN, 1'b0);
    queue_tick(WEIGHT_MIN + 1, 1'b0);
    wait_for_quiet();

    // Change equal to the jitter limit dropped, one above it counted
    configure(1, 2, 16);
    queue_tick(1000, 1'b1);
    queue_tick(1000, 1'b1);
    queue_tick(1000, 1'b1);
    queue_tick(1016, 1'b1);
    queue_tick(1033, 1'b1);
    queue_tick(1033, 1'b1);
    queue_tick(1033, 1'b1);
    queue_tick(1000, 1'b1);
    queue_tick(1000, 1'b0);
    queue_tick(1000, 1'b0);
    wait_for_quiet();

    // Random pours and sips over short periods
    for (int p = 0; p < 5; p++) begin
      configure($urandom_range(4), $urandom_range(12), $urandom_range(200));
      queue_scale_activity(150, $urandom_range(jitter_limit + 8), 20000);
      wait_for_quiet();
    end

    // Saturate the total both ways, no idling on either side
    send_idle_pct  = 0;
    ready_idle_pct = 0;
    configure(1, 4, WEIGHT_MAX);
    queue_accumulator_climb(1'b1);
    queue_accumulator_climb(1'b0);
    wait_for_quiet();
    send_idle_pct  = IDLE_PCT;
    ready_idle_pct = IDLE_PCT;

    // Longest periods: no sample or event within this run
    configure(COUNTER_MAX, COUNTER_MAX, $urandom_range(200));
    queue_scale_activity(40, 50, 20000);
    wait_for_quiet();

    if (mismatch_count == 0) begin
      $display("weight_change_event_detector_tb: PASS");
    end else begin
      $display("weight_change_event_detector_tb: FAIL");
    end
    $finish;
  end

endmodule
